// File: sv/xbs_pkg.sv
// Shared constants and types of the bounded xorshift1024* sampler.
package xbs_pkg;

    // Generator geometry and step constants
    localparam int unsigned GEN_WORDS = 16;
    localparam int unsigned PTR_W     = 4;
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned HALF_W    = 32;
    localparam int unsigned SH_A      = 31;
    localparam int unsigned SH_B      = 11;
    localparam int unsigned SH_C      = 30;
    localparam logic [63:0] GEN_MULT  = 64'd1181783497276652981;

    // Divider step counter width (64 steps)
    localparam int unsigned DIV_CNT_W = 6;

    // Transaction kinds
    localparam logic [1:0] KIND_SEED    = 2'd0;
    localparam logic [1:0] KIND_RAW     = 2'd1;
    localparam logic [1:0] KIND_BOUNDED = 2'd2;

    // Control from sequencer to divider
    typedef struct packed {
        logic start;
    } t_div_ctl;

    // Status from divider to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// File: sv/xbs_if.sv
// Request and response channel interfaces of the sampler.

// Request channel: seed or draw
interface xbs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  seed_index;
    logic [63:0] seed_value;
    logic [63:0] limit;

    modport source (output valid, output kind, output seed_index, output seed_value,
                    output limit, input ready);
    modport sink   (input valid, input kind, input seed_index, input seed_value,
                    input limit, output ready);
endinterface

// Response channel: drawn value
interface xbs_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        bad_limit;

    modport source (output valid, output value, output bad_limit, input ready);
    modport sink   (input valid, input value, input bad_limit, output ready);
endinterface

// File: sv/xbs_div.sv
// Bit-serial restoring divider giving the 64-bit remainder.
module xbs_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  xbs_pkg::t_div_ctl    i_ctl,
    input  logic [63:0]          i_dividend,
    input  logic [63:0]          i_divisor,
    output xbs_pkg::t_div_sts    o_sts,
    output logic [63:0]          o_rem
);

    logic [63:0]                      r_rem;
    logic [63:0]                      r_num;
    logic [63:0]                      r_den;
    logic [xbs_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic                             r_busy;
    logic                             r_done;

    logic [64:0] trial;
    logic [64:0] diff;
    logic [63:0] n_rem;

    // One quotient bit per cycle: shift in next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_num[63]};
        diff  = trial - {1'b0, r_den};
        if (trial >= {1'b0, r_den}) begin
            n_rem = diff[63:0];
        end else begin
            n_rem = trial[63:0];
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == {xbs_pkg::DIV_CNT_W{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[62:0], 1'b0};
        end else if (i_ctl.start) begin
            r_rem <= '0;
            r_num <= i_dividend;
            r_den <= i_divisor;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;

endmodule

// File: sv/xorshift1024_bounded_sampler.sv
// Top level: xorshift1024* generator with rejection-sampled bounded draws.
// Seed transaction: word written when the request is accepted. Raw draw: read, mix, multiply, result.
// Bounded draw: threshold division, one generator step per try until one passes, the
// final remainder, then loading the result; the shared bit-serial divider does both divisions.
// Limit zero: flagged result, no generator step. One transaction in flight; ready only when
// idle; a result not yet taken holds the sequencer. Reset clears pointer and word flags.
module xorshift1024_bounded_sampler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    xbs_req_if.sink       i_req,
    xbs_rsp_if.source     o_rsp
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DTS  = 4'd1;
    localparam logic [3:0] ST_DTW  = 4'd2;
    localparam logic [3:0] ST_RDA  = 4'd3;
    localparam logic [3:0] ST_RDB  = 4'd4;
    localparam logic [3:0] ST_MIX  = 4'd5;
    localparam logic [3:0] ST_M0   = 4'd6;
    localparam logic [3:0] ST_M1   = 4'd7;
    localparam logic [3:0] ST_M2   = 4'd8;
    localparam logic [3:0] ST_M3   = 4'd9;
    localparam logic [3:0] ST_CHK  = 4'd10;
    localparam logic [3:0] ST_DRS  = 4'd11;
    localparam logic [3:0] ST_DRW  = 4'd12;
    localparam logic [3:0] ST_DONE = 4'd13;

    localparam int unsigned PW = xbs_pkg::PTR_W;
    localparam int unsigned HW = xbs_pkg::HALF_W;

    logic [3:0]                      r_state;
    logic [3:0]                      n_state;
    logic [PW-1:0]                   r_ptr;
    logic                            r_bounded;
    logic [63:0]                     r_lim;
    logic [63:0]                     r_thr;
    logic [63:0]                     r_a;
    logic [63:0]                     r_x;
    logic [63:0]                     r_prod;
    logic [63:0]                     r_acc;
    logic [63:0]                     r_res;
    logic                            r_res_bad;
    logic                            r_out_valid;
    logic [63:0]                     r_value;
    logic                            r_bad;

    // State word store
    logic [63:0]                     r_mem [xbs_pkg::GEN_WORDS];
    logic [xbs_pkg::GEN_WORDS-1:0]   r_vld;
    logic [63:0]                     r_rdata;
    logic [PW-1:0]                   rd_addr;
    logic                            wr_en;
    logic [PW-1:0]                   wr_addr;
    logic [63:0]                     wr_data;

    logic                            accept;
    logic [63:0]                     b_sh;
    logic [63:0]                     mix_word;
    logic [HW-1:0]                   mul_a;
    logic [HW-1:0]                   mul_b;
    logic [PW-1:0]                   ptr_inc;

    xbs_pkg::t_div_ctl               div_ctl;
    xbs_pkg::t_div_sts               div_sts;
    logic [63:0]                     div_dividend;
    logic [63:0]                     div_rem;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign ptr_inc     = r_ptr + 1'b1;

    // Generator step on the two fetched words
    always_comb begin
        b_sh     = r_rdata ^ (r_rdata << xbs_pkg::SH_A);
        mix_word = b_sh ^ r_a ^ (b_sh >> xbs_pkg::SH_B) ^ (r_a >> xbs_pkg::SH_C);
    end

    // Read address and write port selection
    always_comb begin
        rd_addr = r_ptr;
        if (r_state == ST_RDB) begin
            rd_addr = ptr_inc;
        end
        wr_en   = 1'b0;
        wr_addr = r_ptr;
        wr_data = mix_word;
        if (accept && i_req.kind == xbs_pkg::KIND_SEED) begin
            wr_en   = 1'b1;
            wr_addr = i_req.seed_index;
            wr_data = (i_req.seed_value == 64'd0) ? 64'd1 : i_req.seed_value;
        end else if (r_state == ST_MIX) begin
            wr_en = 1'b1;
        end
    end

    // Word store: registered read, invalid entries read as one
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_vld[rd_addr] ? r_mem[rd_addr] : 64'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // Shared 32x32 multiplier operand selection (low 64 bits of x * GEN_MULT)
    always_comb begin
        mul_a = r_x[HW-1:0];
        mul_b = xbs_pkg::GEN_MULT[HW-1:0];
        case (r_state)
            ST_M1: begin
                mul_b = xbs_pkg::GEN_MULT[63:HW];
            end
            ST_M2: begin
                mul_a = r_x[63:HW];
            end
            default: begin
                mul_a = r_x[HW-1:0];
            end
        endcase
    end

    // Divider hookup: threshold (2^64 - limit) mod limit, then output mod limit
    assign div_ctl.start = (r_state == ST_DTS) || (r_state == ST_DRS);
    assign div_dividend  = (r_state == ST_DTS) ? (64'd0 - r_lim) : r_acc;

    xbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .i_divisor  (r_lim),
        .o_sts      (div_sts),
        .o_rem      (div_rem)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req.kind)
                        xbs_pkg::KIND_RAW: begin
                            n_state = ST_RDA;
                        end
                        xbs_pkg::KIND_BOUNDED: begin
                            n_state = (i_req.limit == 64'd0) ? ST_DONE : ST_DTS;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DTS: n_state = ST_DTW;
            ST_DTW: begin
                if (div_sts.done) begin
                    n_state = ST_RDA;
                end
            end
            ST_RDA: n_state = ST_RDB;
            ST_RDB: n_state = ST_MIX;
            ST_MIX: n_state = ST_M0;
            ST_M0:  n_state = ST_M1;
            ST_M1:  n_state = ST_M2;
            ST_M2:  n_state = ST_M3;
            ST_M3:  n_state = ST_CHK;
            ST_CHK: begin
                if (!r_bounded) begin
                    n_state = ST_DONE;
                end else if (r_acc < r_thr) begin
                    n_state = ST_RDA;
                end else begin
                    n_state = ST_DRS;
                end
            end
            ST_DRS: n_state = ST_DRW;
            ST_DRW: begin
                if (div_sts.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && i_req.kind == xbs_pkg::KIND_SEED) begin
                r_ptr <= '0;
            end else if (r_state == ST_RDB) begin
                r_ptr <= ptr_inc;
            end
            if (r_state == ST_DONE && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            ST_IDLE: begin
                r_bounded <= (i_req.kind == xbs_pkg::KIND_BOUNDED);
                r_lim     <= i_req.limit;
                r_res     <= 64'd0;
                r_res_bad <= (i_req.limit == 64'd0);
            end
            ST_DTW: begin
                if (div_sts.done) begin
                    r_thr <= div_rem;
                end
            end
            ST_RDB: r_a <= r_rdata;
            ST_MIX: r_x <= mix_word;
            ST_M1:  r_acc <= r_prod;
            ST_M2:  r_acc <= r_acc + {r_prod[HW-1:0], {HW{1'b0}}};
            ST_M3:  r_acc <= r_acc + {r_prod[HW-1:0], {HW{1'b0}}};
            ST_CHK: begin
                r_res_bad <= 1'b0;
                r_res     <= r_acc;
            end
            ST_DRW: begin
                if (div_sts.done) begin
                    r_res <= div_rem;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    r_value <= r_res;
                    r_bad   <= r_res_bad;
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.value     = r_value;
    assign o_rsp.bad_limit = r_bad;

endmodule

// File: tb/sv/tb_xorshift1024_bounded_sampler.sv
// Testbench for the bounded xorshift1024* sampler with an in-bench rejection-sampling predictor.
module tb_xorshift1024_bounded_sampler;

    // Bench timing and run sizes
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 500;
    localparam int LONG_HOLD      = 250;
    localparam int DRAIN_CYCLES   = 300;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    // Generator constants, kept here so the predictor stands apart from the design
    localparam logic [63:0] XS_MULT = 64'd1181783497276652981;
    localparam int          SHL_A   = 31;
    localparam int          SHR_B   = 11;
    localparam int          SHR_C   = 30;

    // The fourth kind code has no meaning and must be dropped by the block
    localparam logic [1:0]  KIND_IGNORED = 2'd3;

    typedef struct packed {
        logic [63:0] value;
        logic        bad_limit;
    } t_draw;

    logic clk;
    logic rst_n;

    xbs_req_if req_if ();
    xbs_rsp_if rsp_if ();

    xorshift1024_bounded_sampler u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Predictor state: sixteen generator words and the rotating pointer
    logic [63:0] gen_state [16];
    logic [3:0]  gen_ptr;
    t_draw       pending_draws [$];

    int err_count    = 0;
    int hold_request = 0;
    bit tx_no_idle   = 1'b0;
    bit rx_no_idle   = 1'b0;

    // Clock
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // One xorshift1024* step; returns the scrambled output
    function automatic logic [63:0] xs_advance();
        logic [63:0] s0;
        logic [63:0] s1;
        s0      = gen_state[gen_ptr];
        gen_ptr = gen_ptr + 4'd1;
        s1      = gen_state[gen_ptr];
        s1      = s1 ^ (s1 << SHL_A);
        gen_state[gen_ptr] = s1 ^ s0 ^ (s1 >> SHR_B) ^ (s0 >> SHR_C);
        return gen_state[gen_ptr] * XS_MULT;
    endfunction

    // Apply one accepted transaction to the predictor, queueing any draw it yields
    function automatic void predict_request(logic [1:0] kind, logic [3:0] idx,
                                            logic [63:0] seed, logic [63:0] lim);
        t_draw       d;
        logic [63:0] thr;
        logic [63:0] r;
        case (kind)
            xbs_pkg::KIND_SEED: begin
                gen_state[idx] = (seed == 64'd0) ? 64'd1 : seed;
                gen_ptr        = 4'd0;
            end
            xbs_pkg::KIND_RAW: begin
                d.value     = xs_advance();
                d.bad_limit = 1'b0;
                pending_draws.push_back(d);
            end
            xbs_pkg::KIND_BOUNDED: begin
                if (lim == 64'd0) begin
                    // zero limit: flagged, generator untouched
                    d.value     = 64'd0;
                    d.bad_limit = 1'b1;
                end else begin
                    // reject outputs below 2^64 mod limit
                    thr = (64'd0 - lim) % lim;
                    do
                        r = xs_advance();
                    while (r < thr);
                    d.value     = r % lim;
                    d.bad_limit = 1'b0;
                end
                pending_draws.push_back(d);
            end
            default: ;  // unused kind: no effect
        endcase
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Limits spread over the interesting regions of the rejection threshold
    function automatic logic [63:0] rand_limit();
        case ($urandom_range(0, 5))
            0:       return 64'($urandom_range(0, 16));
            1:       return rand_word();
            2:       return rand_word() >> $urandom_range(0, 63);
            3:       return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 1024));
            4:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 255));
            default: return 64'd1 << $urandom_range(0, 63);
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ERROR %s", $time, what);
        err_count++;
    endtask

    // Offer one transaction after a random gap and wait for it to be taken
    task automatic send_req(logic [1:0] kind, logic [3:0] idx,
                            logic [63:0] seed, logic [63:0] lim);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.kind       <= kind;
        req_if.seed_index <= idx;
        req_if.seed_value <= seed;
        req_if.limit      <= lim;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        predict_request(kind, idx, seed, lim);
    endtask

    // Stop offering and let every outstanding draw come back
    task automatic settle_pending();
        req_if.valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge clk);
    endtask

    // Compare one returned draw with the oldest prediction
    task automatic check_draw(logic [63:0] got_value, logic got_bad);
        t_draw want;
        if (pending_draws.size() == 0) begin
            report_mismatch($sformatf("unexpected draw value %h bad_limit %b",
                                      got_value, got_bad));
        end else begin
            want = pending_draws.pop_front();
            if (got_value !== want.value)
                report_mismatch($sformatf("value got %h want %h", got_value, want.value));
            if (got_bad !== want.bad_limit)
                report_mismatch($sformatf("bad_limit got %b want %b",
                                          got_bad, want.bad_limit));
        end
    endtask

    // Response side: random hold-offs, before or after the result shows, and checking
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end else begin
                stall = rx_no_idle ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                if (stall <= 5 && $urandom_range(0, 1)) begin
                    // hold off with the result already waiting
                    @(posedge clk);
                    while (!rsp_if.valid) @(posedge clk);
                end
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_if.valid) @(posedge clk);
            check_draw(rsp_if.value, rsp_if.bad_limit);
        end
    end

    // Draws straight out of reset, all words one
    task automatic test_reset_state();
        send_req(xbs_pkg::KIND_RAW, 4'($urandom), rand_word(), rand_word());
        send_req(xbs_pkg::KIND_RAW, 4'($urandom), rand_word(), rand_word());
        send_req(xbs_pkg::KIND_BOUNDED, 4'($urandom), rand_word(), 64'd10);
        settle_pending();
    endtask

    // Seed writes at both index ends, zero seed forced to one, pointer return
    task automatic test_seed_words();
        send_req(xbs_pkg::KIND_SEED, 4'd0, 64'd0, rand_word());
        send_req(xbs_pkg::KIND_SEED, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, rand_word());
        send_req(xbs_pkg::KIND_SEED, 4'd7, 64'h8000_0000_0000_0000, rand_word());
        send_req(xbs_pkg::KIND_RAW, 4'($urandom), rand_word(), rand_word());
        send_req(xbs_pkg::KIND_RAW, 4'($urandom), rand_word(), rand_word());
        send_req(xbs_pkg::KIND_SEED, 4'd3, rand_word(), rand_word());
        send_req(xbs_pkg::KIND_RAW, 4'($urandom), rand_word(), 64'hFFFF_FFFF_FFFF_FFFF);
        settle_pending();
    endtask

    // Zero, one, small, power of two, heavy rejection and largest limits
    task automatic test_bounded_limits();
        send_req(xbs_pkg::KIND_BOUNDED, 4'($urandom), rand_word(), 64'd0);
        send_req(xbs_pkg::KIND_BOUNDED, 4'($urandom), rand_word(), 64'd1);
        send_req(xbs_pkg::KIND_BOUNDED, 4'($urandom), rand_word(), 64'd2);
        send_req(xbs_pkg::KIND_BOUNDED, 4'($urandom), rand_word(), 64'd3);
        send_req(xbs_pkg::KIND_BOUNDED, 4'($urandom), rand_word(), 64'h8000_0000_0000_0000);
        send_req(xbs_pkg::KIND_BOUNDED, 4'($urandom), rand_word(), 64'h8000_0000_0000_0001);
        send_req(xbs_pkg::KIND_BOUNDED, 4'($urandom), rand_word(), 64'hFFFF_FFFF_FFFF_FFFF);
        settle_pending();
    endtask

    // Unused kind leaves the state alone; the following draw proves it
    task automatic test_ignored_kind();
        send_req(KIND_IGNORED, 4'($urandom), rand_word(), rand_word());
        send_req(KIND_IGNORED, 4'd0, 64'd0, 64'd0);
        send_req(xbs_pkg::KIND_RAW, 4'($urandom), rand_word(), rand_word());
        settle_pending();
    endtask

    // Long receiver hold-off while transactions keep coming, so the input stalls
    task automatic test_back_pressure();
        hold_request = LONG_HOLD;
        for (int i = 0; i < 12; i++) begin
            if (i % 2 == 0)
                send_req(xbs_pkg::KIND_RAW, 4'($urandom), rand_word(), rand_word());
            else
                send_req(xbs_pkg::KIND_BOUNDED, 4'($urandom), rand_word(),
                         64'($urandom_range(1, 100)));
        end
        settle_pending();
    endtask

    // Random mix: reseed bursts, single seeds, raw and bounded draws, some noise
    task automatic test_random_mix();
        int counted;
        int pick;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 39) == 0) begin
                // change idling pattern now and then, including stretches with none
                tx_no_idle = ($urandom_range(0, 2) == 0);
                rx_no_idle = ($urandom_range(0, 2) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                for (int i = 0; i < 16; i++)
                    send_req(xbs_pkg::KIND_SEED, 4'(i), rand_word(), rand_word());
                counted += 16;
            end else if (pick < 9) begin
                send_req(xbs_pkg::KIND_SEED, 4'($urandom),
                         ($urandom_range(0, 3) == 0) ? 64'd0 : rand_word(), rand_word());
                counted++;
            end else if (pick < 40) begin
                send_req(xbs_pkg::KIND_RAW, 4'($urandom), rand_word(), rand_word());
                counted++;
            end else if (pick < 96) begin
                send_req(xbs_pkg::KIND_BOUNDED, 4'($urandom), rand_word(), rand_limit());
                counted++;
            end else begin
                send_req(KIND_IGNORED, 4'($urandom), rand_word(), rand_word());
            end
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        settle_pending();
    endtask

    // Main sequence
    initial begin
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.kind       = xbs_pkg::KIND_SEED;
        req_if.seed_index = 4'd0;
        req_if.seed_value = 64'd0;
        req_if.limit      = 64'd0;
        rsp_if.ready      = 1'b0;
        for (int i = 0; i < 16; i++)
            gen_state[i] = 64'd1;
        gen_ptr = 4'd0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_seed_words();
        test_bounded_limits();
        test_ignored_kind();
        test_back_pressure();
        test_random_mix();

        // room for any stray result to show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_xorshift1024_bounded_sampler: clean");
        else
            $display("tb_xorshift1024_bounded_sampler: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("%0t ERROR run timed out", $time);
        $display("tb_xorshift1024_bounded_sampler: errors");
        $finish;
    end

endmodule
